[src/calu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

    // Word and internal widths
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 64;
    localparam int DIV_NW        = 37;   // signed dividend: 17 * 32-bit term
    localparam int SUM_W         = 38;   // Taylor accumulator
    localparam int TERM_DEN_W    = 19;   // widest constant divisor (9!)

    // Parameter defaults
    localparam int MAX_EXP_DEF   = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Taylor divisors
    localparam logic [TERM_DEN_W-1:0] DEN_2      = 19'd2;
    localparam logic [TERM_DEN_W-1:0] DEN_3      = 19'd3;
    localparam logic [TERM_DEN_W-1:0] DEN_6      = 19'd6;
    localparam logic [TERM_DEN_W-1:0] DEN_15     = 19'd15;
    localparam logic [TERM_DEN_W-1:0] DEN_24     = 19'd24;
    localparam logic [TERM_DEN_W-1:0] DEN_120    = 19'd120;
    localparam logic [TERM_DEN_W-1:0] DEN_315    = 19'd315;
    localparam logic [TERM_DEN_W-1:0] DEN_720    = 19'd720;
    localparam logic [TERM_DEN_W-1:0] DEN_5040   = 19'd5040;
    localparam logic [TERM_DEN_W-1:0] DEN_40320  = 19'd40320;
    localparam logic [TERM_DEN_W-1:0] DEN_362880 = 19'd362880;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_SIN = 3'd5,
        OP_COS = 3'd6,
        OP_TAN = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2,
        ST_EXP  = 2'd3
    } t_status;

    // Numerator scale applied to a power before its division
    typedef enum logic [1:0] {
        COEF_1,
        COEF_2,
        COEF_17
    } t_coef;

    typedef struct packed {
        logic                 hit;   // this power feeds a series term
        logic                 last;  // final term of the series
        logic                 neg;   // term is subtracted
        t_coef                coef;
        logic [TERM_DEN_W-1:0] den;
    } t_term;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;  // exact product
        logic signed [WORD_W-1:0] fix;   // fixed-point product, saturated
        logic                     sat;
    } t_mul_rsp;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic signed [WORD_W-1:0] den;   // never zero
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_NW-1:0] quo;   // truncated toward zero
    } t_div_rsp;

    // Series term attached to power k of the angle
    function automatic t_term term_info(input t_op op, input logic [3:0] k);
        t_term t;
        begin
            t      = '0;
            t.coef = COEF_1;
            case (op)
                OP_SIN: begin
                    case (k)
                        4'd3: begin t.hit = 1'b1; t.neg = 1'b1; t.den = DEN_6;   end
                        4'd5: begin t.hit = 1'b1;               t.den = DEN_120; end
                        4'd7: begin t.hit = 1'b1; t.neg = 1'b1; t.den = DEN_5040; end
                        4'd9: begin
                            t.hit  = 1'b1;
                            t.last = 1'b1;
                            t.den  = DEN_362880;
                        end
                        default: t.hit = 1'b0;
                    endcase
                end
                OP_COS: begin
                    case (k)
                        4'd2: begin t.hit = 1'b1; t.neg = 1'b1; t.den = DEN_2;   end
                        4'd4: begin t.hit = 1'b1;               t.den = DEN_24;  end
                        4'd6: begin t.hit = 1'b1; t.neg = 1'b1; t.den = DEN_720; end
                        4'd8: begin
                            t.hit  = 1'b1;
                            t.last = 1'b1;
                            t.den  = DEN_40320;
                        end
                        default: t.hit = 1'b0;
                    endcase
                end
                OP_TAN: begin
                    case (k)
                        4'd3: begin t.hit = 1'b1; t.den = DEN_3; end
                        4'd5: begin t.hit = 1'b1; t.coef = COEF_2; t.den = DEN_15; end
                        4'd7: begin
                            t.hit  = 1'b1;
                            t.last = 1'b1;
                            t.coef = COEF_17;
                            t.den  = DEN_315;
                        end
                        default: t.hit = 1'b0;
                    endcase
                end
                default: t.hit = 1'b0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

[src/calu_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-stage signed multiplier: exact product, then fixed-point rescale
module calu_mul #(
    parameter int FRAC_BITS = calu_pkg::FRAC_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  calu_pkg::t_mul_req i_req,
    output calu_pkg::t_mul_rsp o_rsp
);

    localparam logic [calu_pkg::PROD_W-1:0] RND =
        (calu_pkg::PROD_W'(1) << FRAC_BITS) - calu_pkg::PROD_W'(1);

    logic                                r_v1;
    logic                                r_done;
    logic signed [calu_pkg::PROD_W-1:0]  r_prod;
    logic signed [calu_pkg::WORD_W-1:0]  r_fix;
    logic                                r_sat;

    logic signed [calu_pkg::PROD_W-1:0]  w_biased;
    logic signed [calu_pkg::PROD_W-1:0]  w_shift;
    logic                                w_fits;

    // Truncate toward zero: bias negative products before the shift
    always_comb begin
        w_biased = r_prod + (r_prod[calu_pkg::PROD_W-1] ? $signed(RND) : '0);
        w_shift  = w_biased >>> FRAC_BITS;
        w_fits   = (&w_shift[calu_pkg::PROD_W-1:calu_pkg::WORD_W-1]) ||
                   (~|w_shift[calu_pkg::PROD_W-1:calu_pkg::WORD_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_req.start;
            r_done <= r_v1;
        end
        if (i_req.start) begin
            r_prod <= i_req.a * i_req.b;
        end
        // Saturate to the word range
        if (r_v1) begin
            r_sat <= !w_fits;
            if (w_fits) begin
                r_fix <= w_shift[calu_pkg::WORD_W-1:0];
            end else if (w_shift[calu_pkg::PROD_W-1]) begin
                r_fix <= {1'b1, {(calu_pkg::WORD_W-1){1'b0}}};
            end else begin
                r_fix <= {1'b0, {(calu_pkg::WORD_W-1){1'b1}}};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;
    assign o_rsp.fix  = r_fix;
    assign o_rsp.sat  = r_sat;

endmodule

`default_nettype wire

[src/calu_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, sign fixed up at the end
module calu_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  calu_pkg::t_div_req i_req,
    output calu_pkg::t_div_rsp o_rsp
);

    localparam int NW = calu_pkg::DIV_NW;
    localparam int WW = calu_pkg::WORD_W;
    localparam int CW = $clog2(NW + 1);

    logic                 r_busy;
    logic                 r_sign;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [WW-1:0]        r_rem;
    logic [NW-1:0]        r_quo;
    logic [WW-1:0]        r_den;
    logic                 r_neg;
    logic signed [NW-1:0] r_q;

    logic [NW-1:0]        w_num_mag;
    logic [WW-1:0]        w_den_mag;
    logic [WW:0]          w_rem_sh;
    logic                 w_ge;
    logic [WW:0]          w_diff;

    // Operand magnitudes and one compare-subtract step
    always_comb begin
        w_num_mag = i_req.num[NW-1] ? NW'(-i_req.num) : NW'(i_req.num);
        w_den_mag = i_req.den[WW-1] ? WW'(-i_req.den) : WW'(i_req.den);
        w_rem_sh  = {r_rem, r_quo[NW-1]};
        w_ge      = w_rem_sh >= {1'b0, r_den};
        w_diff    = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= w_num_mag;
                r_den  <= w_den_mag;
                r_neg  <= i_req.num[NW-1] ^ i_req.den[WW-1];
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[WW-1:0] : w_rem_sh[WW-1:0];
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_sign <= 1'b1;
                end
            end else if (r_sign) begin
                r_sign <= 1'b0;
                r_done <= 1'b1;
                r_q    <= r_neg ? -$signed(r_quo) : $signed(r_quo);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

`default_nettype wire

[src/calculator_alu_taylor_trig.sv]
// Add and sub are computed directly; mul is a single multiply and div a single divide;
// power n runs a chain of n fixed-point multiplies (none when out of range or n <= 0);
// sine, cosine and tangent run a Taylor series in which each series term waits on a divide.
// One item at a time: the next item is taken once the result sits in the output register.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module calculator_alu_taylor_trig #(
    parameter int MAX_EXP   = calu_pkg::MAX_EXP_DEF,
    parameter int FRAC_BITS = calu_pkg::FRAC_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire         [2:0] i_op,
    input  wire signed [31:0] i_operand_a,
    input  wire signed [31:0] i_operand_b,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic signed [31:0] o_result,
    output logic        [1:0] o_status
);

    localparam int WW   = calu_pkg::WORD_W;
    localparam int NW   = calu_pkg::DIV_NW;
    localparam int SW   = calu_pkg::SUM_W;
    localparam int EW   = $clog2(MAX_EXP + 1);
    localparam int KW   = (EW > 4) ? EW : 4;
    localparam logic signed [WW-1:0] FX_ONE    = WW'(1) << FRAC_BITS;
    localparam logic signed [WW-1:0] EXP_LIMIT = WW'(MAX_EXP);
    localparam logic signed [WW-1:0] WORD_MAX  = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] WORD_MIN  = {1'b1, {(WW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MULW,
        S_DIVW,
        S_FIN
    } t_state;

    t_state                   r_state,     n_state;
    calu_pkg::t_op            r_op,        n_op;
    logic signed [WW-1:0]     r_a,         n_a;
    logic signed [WW-1:0]     r_b,         n_b;
    logic [KW-1:0]            r_k,         n_k;
    logic signed [WW-1:0]     r_p,         n_p;
    logic signed [SW-1:0]     r_sum,       n_sum;
    logic                     r_ovf,       n_ovf;
    logic signed [WW-1:0]     r_res,       n_res;
    calu_pkg::t_status        r_st,        n_st;
    logic                     r_out_valid, n_out_valid;
    logic signed [WW-1:0]     r_result,    n_result;
    calu_pkg::t_status        r_status,    n_status;

    calu_pkg::t_mul_req       w_mul_req;
    calu_pkg::t_mul_rsp       w_mul_rsp;
    calu_pkg::t_div_req       w_div_req;
    calu_pkg::t_div_rsp       w_div_rsp;
    calu_pkg::t_term          w_term;

    logic signed [WW:0]       w_add;
    logic signed [WW:0]       w_sub;
    logic signed [NW-1:0]     w_p37;
    logic signed [NW-1:0]     w_scaled;
    logic signed [SW-1:0]     w_quo_x;
    logic signed [SW-1:0]     w_sum_next;
    logic                     w_sum_fits;
    logic                     w_prod_fits;
    logic                     w_quo_fits;

    // Shared arithmetic units
    calu_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mul_req),
        .o_rsp  (w_mul_rsp)
    );

    calu_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    // Datapath helpers
    always_comb begin
        w_term      = calu_pkg::term_info(r_op, r_k[3:0]);
        w_add       = {r_a[WW-1], r_a} + {r_b[WW-1], r_b};
        w_sub       = {r_a[WW-1], r_a} - {r_b[WW-1], r_b};
        w_p37       = NW'(w_mul_rsp.fix);
        case (w_term.coef)
            calu_pkg::COEF_2:  w_scaled = w_p37 + w_p37;
            calu_pkg::COEF_17: w_scaled = (w_p37 <<< 4) + w_p37;
            default:           w_scaled = w_p37;
        endcase
        w_quo_x     = SW'(w_div_rsp.quo);
        w_sum_next  = w_term.neg ? (r_sum - w_quo_x) : (r_sum + w_quo_x);
        w_sum_fits  = (&w_sum_next[SW-1:WW-1]) || (~|w_sum_next[SW-1:WW-1]);
        w_prod_fits = (&w_mul_rsp.prod[calu_pkg::PROD_W-1:WW-1]) ||
                      (~|w_mul_rsp.prod[calu_pkg::PROD_W-1:WW-1]);
        w_quo_fits  = (&w_div_rsp.quo[NW-1:WW-1]) || (~|w_div_rsp.quo[NW-1:WW-1]);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_p         = r_p;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_res       = r_res;
        n_st        = r_st;
        n_result    = r_result;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        w_mul_req   = '0;
        w_div_req   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = calu_pkg::t_op'(i_op);
                    n_a     = i_operand_a;
                    n_b     = i_operand_b;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_ovf = 1'b0;
                n_k   = KW'(1);
                n_p   = FX_ONE;
                n_st  = calu_pkg::ST_OK;
                case (r_op)
                    calu_pkg::OP_ADD: begin
                        n_res   = w_add[WW-1:0];
                        n_st    = (w_add[WW] != w_add[WW-1]) ? calu_pkg::ST_OVF
                                                              : calu_pkg::ST_OK;
                        n_state = S_FIN;
                    end
                    calu_pkg::OP_SUB: begin
                        n_res   = w_sub[WW-1:0];
                        n_st    = (w_sub[WW] != w_sub[WW-1]) ? calu_pkg::ST_OVF
                                                              : calu_pkg::ST_OK;
                        n_state = S_FIN;
                    end
                    calu_pkg::OP_MUL: begin
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = r_a;
                        w_mul_req.b     = r_b;
                        n_state         = S_MULW;
                    end
                    calu_pkg::OP_DIV: begin
                        if (r_b == '0) begin
                            n_res   = '0;
                            n_st    = calu_pkg::ST_DIV0;
                            n_state = S_FIN;
                        end else begin
                            w_div_req.start = 1'b1;
                            w_div_req.num   = NW'(r_a);
                            w_div_req.den   = r_b;
                            n_state         = S_DIVW;
                        end
                    end
                    calu_pkg::OP_POW: begin
                        if (r_b > EXP_LIMIT) begin
                            n_res   = '0;
                            n_st    = calu_pkg::ST_EXP;
                            n_state = S_FIN;
                        end else if (r_b < WW'(1)) begin
                            n_res   = FX_ONE;
                            n_state = S_FIN;
                        end else begin
                            w_mul_req.start = 1'b1;
                            w_mul_req.a     = FX_ONE;
                            w_mul_req.b     = r_a;
                            n_state         = S_MULW;
                        end
                    end
                    calu_pkg::OP_SIN, calu_pkg::OP_COS, calu_pkg::OP_TAN: begin
                        n_sum           = (r_op == calu_pkg::OP_COS) ? SW'(FX_ONE) : SW'(r_a);
                        w_mul_req.start = 1'b1;
                        w_mul_req.a     = FX_ONE;
                        w_mul_req.b     = r_a;
                        n_state         = S_MULW;
                    end
                    default: n_state = S_FIN;
                endcase
            end

            // Product result, or power chain: one fixed-point multiply per step, and a divide per series term
            S_MULW: begin
                if (w_mul_rsp.done) begin
                    if (r_op == calu_pkg::OP_MUL) begin
                        n_res   = w_mul_rsp.prod[WW-1:0];
                        n_st    = w_prod_fits ? calu_pkg::ST_OK : calu_pkg::ST_OVF;
                        n_state = S_FIN;
                    end else begin
                        n_p   = w_mul_rsp.fix;
                        n_ovf = r_ovf || w_mul_rsp.sat;
                        if (r_op == calu_pkg::OP_POW) begin
                            if (r_k == r_b[KW-1:0]) begin
                                n_res   = w_mul_rsp.fix;
                                n_st    = n_ovf ? calu_pkg::ST_OVF : calu_pkg::ST_OK;
                                n_state = S_FIN;
                            end else begin
                                n_k             = r_k + KW'(1);
                                w_mul_req.start = 1'b1;
                                w_mul_req.a     = w_mul_rsp.fix;
                                w_mul_req.b     = r_a;
                            end
                        end else if (w_term.hit) begin
                            w_div_req.start = 1'b1;
                            w_div_req.num   = w_scaled;
                            w_div_req.den   = WW'(w_term.den);
                            n_state         = S_DIVW;
                        end else begin
                            n_k             = r_k + KW'(1);
                            w_mul_req.start = 1'b1;
                            w_mul_req.a     = w_mul_rsp.fix;
                            w_mul_req.b     = r_a;
                        end
                    end
                end
            end

            // Quotient: integer result or one series term
            S_DIVW: begin
                if (w_div_rsp.done) begin
                    if (r_op == calu_pkg::OP_DIV) begin
                        n_res   = w_div_rsp.quo[WW-1:0];
                        n_st    = w_quo_fits ? calu_pkg::ST_OK : calu_pkg::ST_OVF;
                        n_state = S_FIN;
                    end else begin
                        n_sum = w_sum_next;
                        if (w_term.last) begin
                            if (w_sum_fits) begin
                                n_res = w_sum_next[WW-1:0];
                            end else begin
                                n_res = w_sum_next[SW-1] ? WORD_MIN : WORD_MAX;
                            end
                            n_st    = (r_ovf || !w_sum_fits) ? calu_pkg::ST_OVF
                                                             : calu_pkg::ST_OK;
                            n_state = S_FIN;
                        end else begin
                            n_k             = r_k + KW'(1);
                            w_mul_req.start = 1'b1;
                            w_mul_req.a     = r_p;
                            w_mul_req.b     = r_a;
                            n_state         = S_MULW;
                        end
                    end
                end
            end

            // Hand the item to the output register once it is empty or being read out
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_result    = r_res;
                    n_status    = r_st;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_k      <= n_k;
        r_p      <= n_p;
        r_sum    <= n_sum;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
        r_st     <= n_st;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an item was taken");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> (w_div_req.den != '0))
        else $error("divider started with a zero divisor");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == calu_pkg::ST_DIV0)) |-> (o_result == '0))
        else $error("divide-by-zero item with nonzero result");

    a_exp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == calu_pkg::ST_EXP)) |-> (o_result == '0))
        else $error("exponent-range item with nonzero result");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_req.start && w_div_req.start))
        else $error("multiplier and divider started together");

endmodule

`default_nettype wire
